>>> src/slm_pkg.sv
// slm_pkg: shared types, widths and constants for the stereo RMS level meter.
// No dependencies; every other file in src imports it.
package slm_pkg;

    localparam int MAX_FRAMES  = 256;   // frames accumulated per buffer at most
    localparam int SMP_W       = 16;    // Q1.15 sample
    localparam int COUNT_W     = 13;    // frame counter
    localparam int SUM_W       = 40;    // Q10.30 square sum
    localparam int LVL_W       = 16;    // Q0.16 levels and weights
    localparam int SCL_W       = 17;    // Q1.16 scaled level
    localparam int DIV_W       = SUM_W; // dividend / quotient width of the shared divider
    localparam int DVR_W       = 16;    // divisor width of the shared divider
    localparam int ROOT_W      = SUM_W / 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam int WEIGHT_ONE  = 65536; // 1.0 in Q0.16
    localparam int ROUND_HALF  = 32768; // 0.5 LSB rounding for the blend
    localparam int SCALE_ONE   = 65536; // 1.0 in Q1.16

    localparam logic [LVL_W-1:0] KEEP_RESET       = 16'd60948; // 0.93
    localparam logic [LVL_W-1:0] FULL_SCALE_RESET = 16'd11141; // 0.17

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_KEEP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 1'd1;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_sample;
        logic signed [SMP_W-1:0] right_sample;
        logic                    last_frame;
    } t_slm_in;

    typedef struct packed {
        logic [LVL_W-1:0] buffer_rms;
        logic [LVL_W-1:0] smoothed_level;
        logic [SCL_W-1:0] scaled_level;
    } t_slm_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_MEAN,
        ST_ROOT,
        ST_BLEND,
        ST_SCALE,
        ST_OUT
    } t_slm_state;

endpackage

>>> src/stereo_rms_level_meter.sv
// stereo_rms_level_meter: top level, sequencer, serial blend multiplier and output register.
// Depends on slm_pkg, slm_sqacc, slm_div and slm_sqrt.
//
// Stereo RMS meter. Each accepted item is one stereo frame; both samples are
// squared by a bit-serial squarer (one partial product per cycle, 16 per
// channel) and added to a saturating 40-bit sum, and the next frame is taken
// only once both squares are in the sum. Frames past MAX_FRAMES in one buffer
// are dropped from the sum. A frame with last_frame set also runs the result
// path: a restoring divide for the mean square, a square root (two bits per
// cycle), a shift-add blend into the smoothed level, and a second pass of the
// same divider to scale against r_full_scale. The result goes to an output
// register; the block takes new frames while it waits there, and only stalls
// if a second result is ready before the first is taken. A full scale of zero
// yields scaled_level 0. Configuration writes are registered, with no read-back,
// and should be made while no buffer is in progress.
module stereo_rms_level_meter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  slm_pkg::t_slm_in                    i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output slm_pkg::t_slm_out                   o_out_data,
    input  logic                                i_cfg_we,
    input  logic [slm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [slm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import slm_pkg::*;

    localparam int BLEND_STEPS = LVL_W + 1;          // keep weight spans 17 bits
    localparam int STEP_W      = $clog2(BLEND_STEPS);
    localparam int BL_W        = 2 * LVL_W + 2;      // two Q0.32 products plus rounding

    t_slm_state         r_state;
    t_slm_state         n_state;

    // config
    logic [LVL_W-1:0]   r_keep;
    logic [LVL_W-1:0]   r_full_scale;

    // datapath
    logic               r_last;
    logic [LVL_W-1:0]   r_rms;
    logic [LVL_W-1:0]   r_level;
    logic [BL_W-1:0]    r_bacc;
    logic [BL_W-1:0]    n_bacc;
    logic [STEP_W-1:0]  r_step;
    logic [SCL_W-1:0]   r_scaled;
    logic               r_out_valid;
    t_slm_out           r_out;

    logic               in_fire;
    logic               out_load;
    logic               acc_start;
    logic               acc_clear;
    logic               acc_busy;
    logic               acc_done;
    logic [SUM_W-1:0]   acc_sum;
    logic [COUNT_W-1:0] acc_count;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DVR_W-1:0]   div_divisor;
    logic               div_busy;
    logic               div_done;
    logic [DIV_W-1:0]   div_quot;
    logic               sqrt_start;
    logic               sqrt_busy;
    logic               sqrt_done;
    logic [ROOT_W-1:0]  sqrt_root;

    logic [LVL_W:0]     keep_w;
    logic [LVL_W:0]     new_w;
    logic [BL_W-1:0]    term_old;
    logic [BL_W-1:0]    term_new;
    logic [LVL_W-1:0]   blend_lvl;
    logic [LVL_W-1:0]   rms_clamped;
    logic [SCL_W-1:0]   scaled_clamped;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);

    slm_sqacc u_sqacc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (acc_start),
        .i_left  (i_in_data.left_sample),
        .i_right (i_in_data.right_sample),
        .i_clear (acc_clear),
        .o_busy  (acc_busy),
        .o_done  (acc_done),
        .o_sum   (acc_sum),
        .o_count (acc_count)
    );

    // one divider: mean square first, then level over full scale
    slm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    slm_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (div_quot),
        .o_busy     (sqrt_busy),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // blend: keep*old + (1-keep)*rms + 0.5, one bit of each weight per cycle
    assign keep_w   = {1'b0, r_keep};
    assign new_w    = (LVL_W+1)'(WEIGHT_ONE) - keep_w;
    assign term_old = keep_w[r_step] ? (BL_W'(r_level) << r_step) : '0;
    assign term_new = new_w[r_step]  ? (BL_W'(r_rms)   << r_step) : '0;
    assign n_bacc   = r_bacc + term_old + term_new;
    assign blend_lvl = (|n_bacc[BL_W-1:2*LVL_W]) ? '1 : n_bacc[2*LVL_W-1:LVL_W];

    assign rms_clamped    = (|sqrt_root[ROOT_W-1:LVL_W]) ? '1 : sqrt_root[LVL_W-1:0];
    assign scaled_clamped = (div_quot > DIV_W'(SCALE_ONE)) ? SCL_W'(SCALE_ONE)
                                                            : div_quot[SCL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        acc_start    = 1'b0;
        acc_clear    = 1'b0;
        div_start    = 1'b0;
        sqrt_start   = 1'b0;
        out_load     = 1'b0;
        div_dividend = acc_sum;
        div_divisor  = DVR_W'({acc_count, 1'b0});
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    acc_start = 1'b1;
                    n_state   = ST_ACC;
                end
            end
            ST_ACC: begin
                if (acc_done) begin
                    if (!r_last) begin
                        n_state = ST_IDLE;
                    end else if (acc_count == '0) begin
                        n_state = ST_BLEND;     // empty buffer: RMS is zero
                    end else begin
                        div_start = 1'b1;
                        n_state   = ST_MEAN;
                    end
                end
            end
            ST_MEAN: begin
                if (div_done) begin
                    sqrt_start = 1'b1;
                    acc_clear  = 1'b1;
                    n_state    = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (sqrt_done) begin
                    n_state = ST_BLEND;
                end
            end
            ST_BLEND: begin
                if (r_step == STEP_W'(BLEND_STEPS-1)) begin
                    div_start    = 1'b1;
                    div_dividend = DIV_W'({blend_lvl, LVL_W'(0)});
                    div_divisor  = r_full_scale;
                    n_state      = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // config registers, smoothed level and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep       <= KEEP_RESET;
            r_full_scale <= FULL_SCALE_RESET;
            r_level      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SMOOTH_KEEP: r_keep       <= i_cfg_data;
                    CFG_FULL_SCALE:  r_full_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_BLEND && r_step == STEP_W'(BLEND_STEPS-1)) begin
                r_level <= blend_lvl;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_last <= i_in_data.last_frame;
        end
        if (r_state == ST_ACC && n_state == ST_BLEND) begin
            r_rms  <= '0;
            r_bacc <= BL_W'(ROUND_HALF);
            r_step <= '0;
        end else if (r_state == ST_ROOT && sqrt_done) begin
            r_rms  <= rms_clamped;
            r_bacc <= BL_W'(ROUND_HALF);
            r_step <= '0;
        end else if (r_state == ST_BLEND) begin
            r_bacc <= n_bacc;
            r_step <= r_step + 1'b1;
        end
        if (r_state == ST_SCALE && div_done) begin
            r_scaled <= (r_full_scale == '0) ? '0 : scaled_clamped;
        end
        if (out_load) begin
            r_out.buffer_rms     <= r_rms;
            r_out.smoothed_level <= r_level;
            r_out.scaled_level   <= r_scaled;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_ready_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!acc_busy && !div_busy && !sqrt_busy))
        else $error("ready while an arithmetic unit is busy");

    a_result_clears_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (acc_count == '0))
        else $error("result issued without clearing the frame count");

    a_scaled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.scaled_level <= SCL_W'(SCALE_ONE)))
        else $error("scaled level above 1.0");

endmodule

>>> src/slm_sqacc.sv
// slm_sqacc: bit-serial squarer feeding the saturating 40-bit square sum and frame count.
// Depends on slm_pkg.
module slm_sqacc (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [slm_pkg::SMP_W-1:0]    i_left,
    input  logic signed [slm_pkg::SMP_W-1:0]    i_right,
    input  logic                                i_clear,
    output logic                                o_busy,
    output logic                                o_done,
    output logic [slm_pkg::SUM_W-1:0]           o_sum,
    output logic [slm_pkg::COUNT_W-1:0]         o_count
);
    import slm_pkg::*;

    localparam int BIT_W = $clog2(SMP_W);

    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   n_sum;
    logic [COUNT_W-1:0] r_count;
    logic [SMP_W-1:0]   r_mcand;
    logic [SMP_W-1:0]   r_mplier;
    logic [SMP_W-1:0]   r_other;
    logic [BIT_W-1:0]   r_bit;
    logic               r_side;
    logic               r_busy;
    logic               r_done;
    logic [SUM_W:0]     add_full;
    logic [SMP_W-1:0]   mag_l;
    logic [SMP_W-1:0]   mag_r;
    logic               room;

    // magnitude; -32768 maps to 16'h8000 read as unsigned 32768
    assign mag_l = i_left[SMP_W-1]  ? SMP_W'(-i_left)  : SMP_W'(i_left);
    assign mag_r = i_right[SMP_W-1] ? SMP_W'(-i_right) : SMP_W'(i_right);
    assign room  = (r_count < COUNT_W'(MAX_FRAMES));

    // one partial product per cycle, added straight into the sum
    assign add_full = {1'b0, r_sum}
                    + ((SUM_W+1)'(r_mplier[0] ? r_mcand : '0) << r_bit);
    assign n_sum    = add_full[SUM_W] ? '1 : add_full[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_count  <= '0;
            r_mcand  <= '0;
            r_mplier <= '0;
            r_other  <= '0;
            r_bit    <= '0;
            r_side   <= 1'b0;
            r_busy   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_clear) begin
                r_sum   <= '0;
                r_count <= '0;
            end else if (i_start && !r_busy) begin
                if (room) begin
                    r_busy   <= 1'b1;
                    r_side   <= 1'b0;
                    r_bit    <= '0;
                    r_mcand  <= mag_l;
                    r_mplier <= mag_l;
                    r_other  <= mag_r;
                end else begin
                    // buffer full: frame is dropped
                    r_done <= 1'b1;
                end
            end else if (r_busy) begin
                r_sum    <= n_sum;
                r_mplier <= r_mplier >> 1;
                r_bit    <= r_bit + 1'b1;
                if (r_bit == BIT_W'(SMP_W-1)) begin
                    if (!r_side) begin
                        r_side   <= 1'b1;
                        r_mcand  <= r_other;
                        r_mplier <= r_other;
                    end else begin
                        r_busy  <= 1'b0;
                        r_done  <= 1'b1;
                        r_count <= r_count + 1'b1;
                    end
                end
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_done  = r_done;
    assign o_sum   = r_sum;
    assign o_count = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(MAX_FRAMES))
        else $error("frame count above MAX_FRAMES");

    a_sum_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_clear)) |-> (r_sum >= $past(r_sum)))
        else $error("square sum decreased without a clear");

endmodule

>>> src/slm_div.sv
// slm_div: restoring divider, one quotient bit per cycle, shared by mean and scaling.
// Depends on slm_pkg.
module slm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [slm_pkg::DIV_W-1:0]   i_dividend,
    input  logic [slm_pkg::DVR_W-1:0]   i_divisor,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [slm_pkg::DIV_W-1:0]   o_quot
);
    import slm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_quot;
    logic [DVR_W-1:0] r_rem;
    logic [DVR_W-1:0] r_dvr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVR_W:0]   trial;
    logic [DVR_W:0]   diff;
    logic             fits;

    // dividend bits shift out the top of r_quot as quotient bits shift in
    assign trial = {r_rem, r_quot[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvr};
    assign fits  = (trial >= {1'b0, r_dvr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quot <= '0;
            r_rem  <= '0;
            r_dvr  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_quot <= i_dividend;
                r_dvr  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(DIV_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? diff[DVR_W-1:0] : trial[DVR_W-1:0];
                r_quot <= {r_quot[DIV_W-2:0], fits};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> src/slm_sqrt.sv
// slm_sqrt: digit-by-digit floored square root, two radicand bits per cycle.
// Depends on slm_pkg.
module slm_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [slm_pkg::SUM_W-1:0]   i_radicand,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [slm_pkg::ROOT_W-1:0]  o_root
);
    import slm_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [SUM_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+1:0] r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic              fits;

    // remainder stays below 2^ROOT_W before the shift, so its top bits drop
    assign rem_sh = {r_rem[ROOT_W-1:0], r_rad[SUM_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad  <= '0;
            r_root <= '0;
            r_rem  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_rad  <= i_radicand;
                r_root <= '0;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(ROOT_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[ROOT_W-2:0], fits};
                r_rad  <= r_rad << 2;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

endmodule
